// File: design/lqfl_pkg.sv
// Shared types and constants for the linked byte queue.
// Holds the operation codes and the fixed field widths used by all files but lqfl_ram.
package lqfl_pkg;

  // Field widths fixed by the item format
  localparam int OpW   = 3;
  localparam int ByteW = 8;
  localparam int PosW  = 8;

  // Operation codes; codes 5 to 7 are accepted and leave the queue unchanged
  typedef enum logic [OpW-1:0] {
    OP_ENQUEUE    = 3'd0,
    OP_DEQUEUE    = 3'd1,
    OP_INS_FRONT  = 3'd2,
    OP_INS_POS    = 3'd3,
    OP_MAKE_EMPTY = 3'd4
  } op_e;

endpackage

// File: design/lqfl_if.sv
// Valid/ready channel interfaces for the linked byte queue.
// Depends on lqfl_pkg for the field widths.
interface lqfl_req_if;
  logic                        valid;
  logic                        ready;
  logic [lqfl_pkg::OpW-1:0]    operation;
  logic [lqfl_pkg::ByteW-1:0]  elem;
  logic [lqfl_pkg::PosW-1:0]   position;

  modport source (output valid, operation, elem, position, input ready);
  modport sink   (input valid, operation, elem, position, output ready);
endinterface

interface lqfl_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [lqfl_pkg::ByteW-1:0]  front_value;
  logic                        is_empty;
  logic                        is_full;

  modport source (output valid, front_value, is_empty, is_full, input ready);
  modport sink   (input valid, front_value, is_empty, is_full, output ready);
endinterface

// File: design/lqfl_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port,
// read data registered. No dependencies.
module lqfl_ram #(
  parameter int Depth = 16,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write and read; a read of the address written in the same cycle sees old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/lqfl_seq.sv
// Sequencer of the linked byte queue: walks and rewrites the link store,
// writes the value store and holds the result register.
// Depends on lqfl_pkg and the channel interfaces in lqfl_if.sv.
module lqfl_seq #(
  parameter int DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  lqfl_req_if.sink                          req,
  lqfl_rsp_if.source                        rsp,
  // link store port
  output logic                              link_we_o,
  output logic [$clog2(DEPTH)-1:0]          link_waddr_o,
  output logic [$clog2(DEPTH+1)-1:0]        link_wdata_o,
  output logic [$clog2(DEPTH)-1:0]          link_raddr_o,
  input  logic [$clog2(DEPTH+1)-1:0]        link_rdata_i,
  // value store port
  output logic                              val_we_o,
  output logic [$clog2(DEPTH)-1:0]          val_waddr_o,
  output logic [lqfl_pkg::ByteW-1:0]        val_wdata_o,
  output logic [$clog2(DEPTH)-1:0]          val_raddr_o,
  input  logic [lqfl_pkg::ByteW-1:0]        val_rdata_i
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] Nil = PW'(DEPTH);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_TAKE_RD,
    ST_TAKE,
    ST_WALK,
    ST_INS,
    ST_INS_LINK,
    ST_POP,
    ST_DROP,
    ST_DROP_FREE,
    ST_FRONT,
    ST_OUT
  } state_e;

  state_e                        state_q;
  logic [AW-1:0]                 init_q;
  logic [PW-1:0]                 head_q;
  logic [PW-1:0]                 free_q;
  logic [PW-1:0]                 node_q;
  logic [PW-1:0]                 cur_q;
  logic [PW-1:0]                 prev_q;
  logic [lqfl_pkg::PosW-1:0]     k_q;
  logic [lqfl_pkg::OpW-1:0]      op_q;
  logic [lqfl_pkg::ByteW-1:0]    elem_q;
  logic [lqfl_pkg::PosW-1:0]     pos_q;
  logic                          out_valid_q;
  logic [lqfl_pkg::ByteW-1:0]    out_front_q;
  logic                          out_empty_q;
  logic                          out_full_q;

  logic head_nil;
  logic free_nil;
  logic rd_nil;
  logic pos_ok;

  assign head_nil = (head_q == Nil);
  assign free_nil = (free_q == Nil);
  assign rd_nil   = (link_rdata_i == Nil);
  assign pos_ok   = (int'(req.position) < DEPTH);

  assign req.ready       = (state_q == ST_IDLE);
  assign rsp.valid       = out_valid_q;
  assign rsp.front_value = out_front_q;
  assign rsp.is_empty    = out_empty_q;
  assign rsp.is_full     = out_full_q;

  // Drive the store ports for the current step
  always_comb begin
    link_we_o    = 1'b0;
    link_waddr_o = cur_q[AW-1:0];
    link_wdata_o = Nil;
    link_raddr_o = head_q[AW-1:0];
    val_we_o     = 1'b0;
    val_waddr_o  = node_q[AW-1:0];
    val_wdata_o  = elem_q;
    val_raddr_o  = head_q[AW-1:0];
    case (state_q)
      ST_INIT: begin
        link_we_o    = 1'b1;
        link_waddr_o = init_q;
        link_wdata_o = (init_q == '0) ? Nil : PW'(init_q) - PW'(1);
      end
      ST_TAKE_RD: begin
        link_raddr_o = free_q[AW-1:0];
      end
      ST_TAKE: begin
        // write the new node; start a walk from the head at the same time
        val_we_o     = 1'b1;
        link_we_o    = 1'b1;
        link_waddr_o = node_q[AW-1:0];
        link_wdata_o = (op_q == lqfl_pkg::OP_ENQUEUE) ? Nil : head_q;
        link_raddr_o = head_q[AW-1:0];
      end
      ST_WALK: begin
        if (rd_nil) begin
          link_we_o    = 1'b1;
          link_wdata_o = node_q;
        end else begin
          link_raddr_o = link_rdata_i[AW-1:0];
        end
      end
      ST_INS: begin
        if (k_q < pos_q && !rd_nil) begin
          link_raddr_o = link_rdata_i[AW-1:0];
        end else begin
          link_we_o    = 1'b1;
          link_waddr_o = node_q[AW-1:0];
          link_wdata_o = link_rdata_i;
        end
      end
      ST_INS_LINK: begin
        link_we_o    = 1'b1;
        link_wdata_o = node_q;
      end
      ST_POP: begin
        link_we_o    = 1'b1;
        link_waddr_o = head_q[AW-1:0];
        link_wdata_o = free_q;
        link_raddr_o = link_rdata_i[AW-1:0];
      end
      ST_DROP: begin
        if (!rd_nil) begin
          link_raddr_o = link_rdata_i[AW-1:0];
        end else if (cur_q == head_q) begin
          link_we_o    = 1'b1;
          link_wdata_o = free_q;
        end else begin
          link_we_o    = 1'b1;
          link_waddr_o = prev_q[AW-1:0];
          link_wdata_o = Nil;
        end
      end
      ST_DROP_FREE: begin
        link_we_o    = 1'b1;
        link_wdata_o = free_q;
      end
      default: begin
      end
    endcase
  end

  // State, list pointers and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_q      <= '0;
      head_q      <= Nil;
      free_q      <= PW'(DEPTH - 1);
      node_q      <= Nil;
      cur_q       <= Nil;
      prev_q      <= Nil;
      k_q         <= '0;
      op_q        <= '0;
      elem_q      <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      out_front_q <= '0;
      out_empty_q <= 1'b1;
      out_full_q  <= 1'b0;
    end else begin
      // drop the result once it is taken, unless a new one replaces it
      if (out_valid_q && rsp.ready && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_INIT: begin
          init_q <= init_q + AW'(1);
          if (init_q == AW'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            op_q   <= req.operation;
            elem_q <= req.elem;
            pos_q  <= (req.operation == lqfl_pkg::OP_INS_FRONT) ? '0 : req.position;
            cur_q  <= head_q;
            case (req.operation)
              lqfl_pkg::OP_ENQUEUE:    state_q <= free_nil ? ST_FRONT : ST_TAKE_RD;
              lqfl_pkg::OP_DEQUEUE:    state_q <= head_nil ? ST_FRONT : ST_POP;
              lqfl_pkg::OP_INS_FRONT:  state_q <= free_nil ? ST_DROP : ST_TAKE_RD;
              lqfl_pkg::OP_INS_POS: begin
                if (!pos_ok) begin
                  state_q <= ST_FRONT;
                end else begin
                  state_q <= free_nil ? ST_DROP : ST_TAKE_RD;
                end
              end
              lqfl_pkg::OP_MAKE_EMPTY: state_q <= head_nil ? ST_FRONT : ST_POP;
              default:                 state_q <= ST_FRONT;
            endcase
          end
        end
        ST_TAKE_RD: begin
          node_q  <= free_q;
          state_q <= ST_TAKE;
        end
        ST_TAKE: begin
          free_q <= link_rdata_i;
          cur_q  <= head_q;
          k_q    <= lqfl_pkg::PosW'(1);
          if (op_q == lqfl_pkg::OP_ENQUEUE) begin
            if (head_nil) begin
              head_q  <= node_q;
              state_q <= ST_FRONT;
            end else begin
              state_q <= ST_WALK;
            end
          end else if (pos_q == '0 || head_nil) begin
            head_q  <= node_q;
            state_q <= ST_FRONT;
          end else begin
            state_q <= ST_INS;
          end
        end
        ST_WALK: begin
          // advance to the tail; link it to the new node there
          if (rd_nil) begin
            state_q <= ST_FRONT;
          end else begin
            cur_q <= link_rdata_i;
          end
        end
        ST_INS: begin
          if (k_q < pos_q && !rd_nil) begin
            cur_q <= link_rdata_i;
            k_q   <= k_q + lqfl_pkg::PosW'(1);
          end else begin
            state_q <= ST_INS_LINK;
          end
        end
        ST_INS_LINK: begin
          state_q <= ST_FRONT;
        end
        ST_POP: begin
          head_q <= link_rdata_i;
          free_q <= head_q;
          if (!(op_q == lqfl_pkg::OP_MAKE_EMPTY && !rd_nil)) begin
            state_q <= ST_FRONT;
          end
        end
        ST_DROP: begin
          if (!rd_nil) begin
            prev_q <= cur_q;
            cur_q  <= link_rdata_i;
          end else if (cur_q == head_q) begin
            head_q  <= Nil;
            free_q  <= cur_q;
            state_q <= ST_TAKE_RD;
          end else begin
            state_q <= ST_DROP_FREE;
          end
        end
        ST_DROP_FREE: begin
          free_q  <= cur_q;
          state_q <= ST_TAKE_RD;
        end
        ST_FRONT: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          // hold until the result register is free
          if (!out_valid_q || rsp.ready) begin
            out_valid_q <= 1'b1;
            out_front_q <= head_nil ? '0 : val_rdata_i;
            out_empty_q <= head_nil;
            out_full_q  <= free_nil;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/linked_queue_with_free_list_core.sv
// Linked byte queue with a free list: the queue is a singly linked list of
// nodes in a DEPTH-entry link store and a DEPTH-entry value store, with unused
// nodes chained on a free list. After reset the block writes the initial free
// chain into the link store and takes no item until that is done. An enqueue
// into a non-empty queue walks to the tail and links the new node there;
// make-empty pops the nodes in turn; insert at position walks the nodes up to
// the position and then relinks. An insert into a full store first walks to
// the tail to drop it. The rate is set by the pointer chase through the link
// store read port, one hop per cycle. One result item follows each input
// item; a finished result waits in an output register while the next item
// is accepted.
// Depends on lqfl_pkg, lqfl_if.sv, lqfl_ram and lqfl_seq.
module linked_queue_with_free_list_core #(
  parameter int DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lqfl_req_if.sink   req_i,
  lqfl_rsp_if.source rsp_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = $clog2(DEPTH + 1);

  logic                       link_we;
  logic [AW-1:0]              link_waddr;
  logic [PW-1:0]              link_wdata;
  logic [AW-1:0]              link_raddr;
  logic [PW-1:0]              link_rdata;
  logic                       val_we;
  logic [AW-1:0]              val_waddr;
  logic [lqfl_pkg::ByteW-1:0] val_wdata;
  logic [AW-1:0]              val_raddr;
  logic [lqfl_pkg::ByteW-1:0] val_rdata;

  // Sequencer
  lqfl_seq #(.DEPTH(DEPTH)) u_seq (
    .clk_i,
    .rst_ni,
    .req          (req_i),
    .rsp          (rsp_o),
    .link_we_o    (link_we),
    .link_waddr_o (link_waddr),
    .link_wdata_o (link_wdata),
    .link_raddr_o (link_raddr),
    .link_rdata_i (link_rdata),
    .val_we_o     (val_we),
    .val_waddr_o  (val_waddr),
    .val_wdata_o  (val_wdata),
    .val_raddr_o  (val_raddr),
    .val_rdata_i  (val_rdata)
  );

  // Link store: next node or null per node
  lqfl_ram #(.Depth(DEPTH), .Width(PW)) u_link_ram (
    .clk_i,
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  // Value store: one byte per node
  lqfl_ram #(.Depth(DEPTH), .Width(lqfl_pkg::ByteW)) u_val_ram (
    .clk_i,
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

endmodule

// File: design/lqfl_chk.sv
// Port-level checker for the linked byte queue, bound to the top level.
// Depends on lqfl_pkg and linked_queue_with_free_list_core.
module lqfl_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [lqfl_pkg::ByteW-1:0] front_value_i,
  input logic                       is_empty_i,
  input logic                       is_full_i
);

  // An empty queue reports a zero front byte
  a_empty_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && is_empty_i |-> front_value_i == '0)
    else $error("front byte not zero on empty queue");

  // An empty queue is never reported full
  a_empty_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(is_empty_i && is_full_i))
    else $error("queue reported empty and full");

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(front_value_i) && $stable(is_empty_i) && $stable(is_full_i))
    else $error("stalled result changed");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("item accepted while another is in work");

endmodule

bind linked_queue_with_free_list_core lqfl_chk u_lqfl_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .front_value_i (rsp_o.front_value),
  .is_empty_i    (rsp_o.is_empty),
  .is_full_i     (rsp_o.is_full)
);
